[rtl/core/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	// Field widths
	localparam int unsigned TimeW  = 32;
	localparam int unsigned ThrW   = 16;
	localparam int unsigned CountW = 2;
	localparam int unsigned AddrW  = 4;
	localparam int unsigned DataW  = 32;
	localparam int unsigned InDataW  = 40; // level + timestamp, padded to bytes
	localparam int unsigned OutDataW = 8;  // event code, padded to a byte

	// Register reset values
	localparam logic [ThrW-1:0] LongPressRst = 16'd3000;
	localparam logic [ThrW-1:0] DebounceRst  = 16'd50;
	localparam logic [ThrW-1:0] ClickGapRst  = 16'd400;

	// Saturation limit of the click counter
	localparam logic [CountW-1:0] CountMax = 2'd3;

	// Register indexes (word address bits)
	typedef enum logic [1:0] {
		REG_LONG_PRESS = 2'd0,
		REG_DEBOUNCE   = 2'd1,
		REG_CLICK_GAP  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	// Reported events
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	// Thresholds handed from the register file to the classifier
	typedef struct packed {
		logic [ThrW-1:0] long_press_ms;
		logic [ThrW-1:0] debounce_ms;
		logic [ThrW-1:0] click_gap_ms;
	} cfg_t;

endpackage

[rtl/core/button_click_classifier.sv]
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies an active-low button sample stream into single, double and
// long presses.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one output transfer carrying the event
// code (0 none, 1 single, 2 double, 3 long). Throughput is one sample per
// clock while the output side is ready: a sample lands in the input register,
// is classified against the state registers and written to the output
// register. Thresholds are written over APB and should only be changed while
// no samples are in flight.
module button_click_classifier import bcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Sample stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // [0] button_level, [32:1] now_ms, zero pad
	// Event stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // [1:0] event_res, zero pad
	// Configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrW-1:0]    paddr,
	input  logic [DataW-1:0]    pwdata,
	output logic [DataW-1:0]    prdata,
	output logic                pready
);

	cfg_t             cfg;
	logic             valid_s1;
	logic             level_s1;
	logic [TimeW-1:0] now_s1;
	logic             out_valid_q;
	event_t           ev_q;
	event_t           ev;
	logic             out_free;
	logic             fire;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW-2){1'b0}}, ev_q};

	bcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcc_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.level  (level_s1),
		.now_ms (now_s1),
		.ev     (ev)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
			now_s1   <= s_tdata[TimeW:1];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q <= ev;
		end
	end

endmodule

[rtl/core/bcc_cfg.sv]
// ----------------------------------------------------------------------------
// bcc_cfg
// APB register file holding the three timing thresholds.
// ----------------------------------------------------------------------------
module bcc_cfg import bcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms <= LongPressRst;
			cfg_q.debounce_ms   <= DebounceRst;
			cfg_q.click_gap_ms  <= ClickGapRst;
		end else if (wr_en) begin
			unique case (idx)
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[ThrW-1:0];
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[ThrW-1:0];
				REG_CLICK_GAP:  cfg_q.click_gap_ms  <= pwdata[ThrW-1:0];
				REG_UNUSED:     ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_LONG_PRESS: prdata = {{(DataW-ThrW){1'b0}}, cfg_q.long_press_ms};
			REG_DEBOUNCE:   prdata = {{(DataW-ThrW){1'b0}}, cfg_q.debounce_ms};
			REG_CLICK_GAP:  prdata = {{(DataW-ThrW){1'b0}}, cfg_q.click_gap_ms};
			REG_UNUSED:     prdata = '0;
		endcase
	end

endmodule

[rtl/core/bcc_classify.sv]
// ----------------------------------------------------------------------------
// bcc_classify
// Press/release tracking state and the single-pass event decision.
// ----------------------------------------------------------------------------
module bcc_classify import bcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             fire,
	input  logic             level,
	input  logic [TimeW-1:0] now_ms,
	output event_t           ev
);

	logic              last_level_q;
	logic [TimeW-1:0]  press_start_q;
	logic [CountW-1:0] click_count_q;
	logic [TimeW-1:0]  last_click_q;

	logic              fall;
	logic              rise;
	logic [TimeW-1:0]  held;
	logic [TimeW-1:0]  gap;
	logic [TimeW-1:0]  press_start_d;
	logic [CountW-1:0] count_mid;
	logic [CountW-1:0] click_count_d;
	logic [TimeW-1:0]  last_click_d;

	assign fall = last_level_q && !level;
	assign rise = !last_level_q && level;
	assign held = now_ms - press_start_q;
	assign gap  = now_ms - last_click_d;

	// Edge handling, then gap expiry on the updated count
	always_comb begin
		ev            = EV_NONE;
		press_start_d = fall ? now_ms : press_start_q;
		count_mid     = click_count_q;
		last_click_d  = last_click_q;
		if (rise) begin
			if (held > {{(TimeW-ThrW){1'b0}}, cfg.long_press_ms}) begin
				ev        = EV_LONG;
				count_mid = '0;
			end else if (held > {{(TimeW-ThrW){1'b0}}, cfg.debounce_ms}) begin
				if (click_count_q != CountMax) begin
					count_mid = click_count_q + CountW'(1);
				end
				last_click_d = now_ms;
			end
		end
		click_count_d = count_mid;
		if ((count_mid != '0) && (gap > {{(TimeW-ThrW){1'b0}}, cfg.click_gap_ms})) begin
			if (count_mid == CountW'(2)) begin
				ev = EV_DOUBLE;
			end else if (count_mid == CountW'(1)) begin
				ev = EV_SINGLE;
			end
			click_count_d = '0;
		end
	end

	// State registers, advanced once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b1;
			press_start_q <= '0;
			click_count_q <= '0;
			last_click_q  <= '0;
		end else if (fire) begin
			last_level_q  <= level;
			press_start_q <= press_start_d;
			click_count_q <= click_count_d;
			last_click_q  <= last_click_d;
		end
	end

	// A single click can only come from one pending click
	a_single_from_one: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (ev == EV_SINGLE) |-> (click_count_q == CountW'(1)))
		else $error("single click without exactly one pending click");

	// A double click can only come from two pending clicks
	a_double_from_two: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (ev == EV_DOUBLE) |-> (click_count_q == CountW'(2)))
		else $error("double click without two pending clicks");

	// Any reported event clears the click count
	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (ev != EV_NONE) |=> (click_count_q == '0))
		else $error("click count not cleared after event");

	// State holds between transfers
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(click_count_q) && $stable(press_start_q) && $stable(last_level_q))
		else $error("classifier state changed without a transfer");

endmodule

[tb/button_click_classifier_test.sv]
// ----------------------------------------------------------------------------
// button_click_classifier_test
// Self-checking testbench for the button click classifier. A short table of
// hand-picked samples covers the threshold edges, every event kind, counter
// saturation and timestamp wrap. Random press/release gestures then run under
// several threshold settings, including all-zero and all-max. Both stream
// sides idle at random. Every event is checked against an in-bench predictor,
// and every threshold register is read back after each write.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module button_click_classifier_test;
	import bcc_pkg::*;

	localparam int ScriptLen = 26;
	localparam int PhaseLen  = 310;
	localparam int Phases    = 6;

	typedef struct {
		logic        level;
		logic [31:0] stamp;
		logic        typed;
		event_t      want;
	} script_row_t;

	// Directed samples at reset thresholds (3000 / 50 / 400)
	script_row_t script [ScriptLen] = '{
		'{1'b1, 32'd0,          1'b1, EV_NONE},   // idle after reset
		'{1'b0, 32'd100,        1'b0, EV_NONE},
		'{1'b1, 32'd3101,       1'b1, EV_LONG},   // held 3001
		'{1'b0, 32'd4000,       1'b0, EV_NONE},
		'{1'b1, 32'd7000,       1'b0, EV_NONE},   // held exactly 3000: click
		'{1'b1, 32'd7400,       1'b0, EV_NONE},   // gap exactly 400
		'{1'b1, 32'd7401,       1'b1, EV_SINGLE},
		'{1'b0, 32'd8000,       1'b0, EV_NONE},
		'{1'b1, 32'd8051,       1'b0, EV_NONE},   // held 51: click
		'{1'b0, 32'd8100,       1'b0, EV_NONE},
		'{1'b1, 32'd8150,       1'b0, EV_NONE},   // held 50: bounce
		'{1'b0, 32'd8200,       1'b0, EV_NONE},
		'{1'b1, 32'd8300,       1'b0, EV_NONE},
		'{1'b1, 32'd8701,       1'b1, EV_DOUBLE},
		'{1'b0, 32'd9000,       1'b0, EV_NONE},   // four clicks: count saturates
		'{1'b1, 32'd9100,       1'b0, EV_NONE},
		'{1'b0, 32'd9200,       1'b0, EV_NONE},
		'{1'b1, 32'd9300,       1'b0, EV_NONE},
		'{1'b0, 32'd9400,       1'b0, EV_NONE},
		'{1'b1, 32'd9500,       1'b0, EV_NONE},
		'{1'b0, 32'd9600,       1'b0, EV_NONE},
		'{1'b1, 32'd9700,       1'b0, EV_NONE},
		'{1'b1, 32'd10101,      1'b1, EV_NONE},   // many clicks report nothing
		'{1'b0, 32'hFFFF_FF00,  1'b0, EV_NONE},   // press just before wrap
		'{1'b1, 32'h0000_0100,  1'b0, EV_NONE},   // held 512 across wrap
		'{1'b1, 32'hFFFF_FFFF,  1'b1, EV_SINGLE}
	};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata  = '0;  // [0] button_level, [32:1] now_ms, zero pad
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;        // [1:0] event_res, zero pad
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [AddrW-1:0]    paddr    = '0;
	logic [DataW-1:0]    pwdata   = '0;
	logic [DataW-1:0]    prdata;
	logic                pready;

	button_click_classifier dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state and thresholds
	cfg_t        thr = '{LongPressRst, DebounceRst, ClickGapRst};
	logic        prev_level = 1'b1;
	logic [31:0] press_t    = '0;
	logic [1:0]  clicks     = '0;
	logic [31:0] click_t    = '0;

	event_t      pending_events [$];
	int          fault_count  = 0;
	int          samples_sent = 0;
	int          ev_tally [4] = '{0, 0, 0, 0};
	bit          steady       = 1'b0;
	int          stall_left   = 0;
	logic [31:0] clock_ms     = '0;
	event_t      want;

	function automatic event_t classify(input logic level, input logic [31:0] now);
		event_t      ev;
		logic [31:0] held;
		ev = EV_NONE;
		if (prev_level && !level)
			press_t = now;
		if (!prev_level && level) begin
			held = now - press_t;
			if (held > thr.long_press_ms) begin
				ev = EV_LONG;
				clicks = '0;
			end else if (held > thr.debounce_ms) begin
				if (clicks != CountMax)
					clicks = clicks + 2'd1;
				click_t = now;
			end
		end
		// Gap expiry closes a pending click sequence
		if (clicks != 0 && (now - click_t) > thr.click_gap_ms) begin
			if (clicks == 2'd2)
				ev = EV_DOUBLE;
			else if (clicks == 2'd1)
				ev = EV_SINGLE;
			clicks = '0;
		end
		prev_level = level;
		return ev;
	endfunction

	// Idle length: mostly none or short, rarely long
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Duration on or close to a threshold
	function automatic logic [31:0] near(input logic [ThrW-1:0] edge_ms);
		logic [31:0] x;
		x = {16'd0, edge_ms};
		case ($urandom_range(0, 5))
			0: return x - 32'd1;
			1: return x;
			2: return x + 32'd1;
			3: return $urandom_range(0, x + 10);
			4: return x + $urandom_range(2, 500);
			default: return $urandom_range(0, 20);
		endcase
	endfunction

	function automatic logic [ThrW-1:0] thr_field(input cfg_t c, input reg_idx_t idx);
		case (idx)
			REG_LONG_PRESS: return c.long_press_ms;
			REG_DEBOUNCE:   return c.debounce_ms;
			default:        return c.click_gap_ms;
		endcase
	endfunction

	task automatic note_fault(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, act_v);
	endtask

	// Event side: random stalls and in-order checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_events.size() == 0) begin
					note_fault("event with nothing pending", 32'd0, 32'(m_tdata));
				end else begin
					want = pending_events.pop_front();
					ev_tally[want]++;
					if (m_tdata !== {{(OutDataW-2){1'b0}}, want})
						note_fault("event", 32'(want), 32'(m_tdata));
				end
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// One sample transfer; the predictor runs at acceptance
	task automatic send_sample(input logic level, input logic [31:0] now,
			input logic typed, input event_t typed_ev);
		int     gap;
		event_t ev;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= InDataW'({now, level});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ev = classify(level, now);
		pending_events.push_back(typed ? typed_ev : ev);
		samples_sent++;
	endtask

	// Stop feeding and let every event come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t idx,
			input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all thresholds and poke the unused slot if asked, then read the three thresholds back
	task automatic apply_thresholds(input cfg_t c, input logic do_write);
		logic [DataW-1:0] rd;
		reg_idx_t         idx;
		if (do_write) begin
			for (int i = 0; i < 3; i++) begin
				idx = reg_idx_t'(i);
				apb_access(1'b1, idx, {16'd0, thr_field(c, idx)}, rd);
			end
			apb_access(1'b1, REG_UNUSED, {16'd0, 16'($urandom)}, rd);
			thr = c;
		end
		for (int i = 0; i < 3; i++) begin
			idx = reg_idx_t'(i);
			apb_access(1'b0, idx, '0, rd);
			if (rd !== {16'd0, thr_field(thr, idx)})
				note_fault("threshold readback", {16'd0, thr_field(thr, idx)}, rd);
		end
	endtask

	function automatic logic [31:0] pick_hold();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return near(thr.long_press_ms);
		if (r < 4)
			return near(thr.debounce_ms);
		return {16'd0, thr.debounce_ms} + 32'd1 + $urandom_range(0, 200);
	endfunction

	// Well-formed click sequence: one to four presses, then the gap runs out
	task automatic run_gesture();
		int          n;
		logic [31:0] held;
		n = $urandom_range(1, 4);
		for (int k = 0; k < n; k++) begin
			send_sample(1'b0, clock_ms, 1'b0, EV_NONE);
			held = pick_hold();
			if ($urandom_range(0, 3) == 0)
				send_sample(1'b0, clock_ms + held / 2, 1'b0, EV_NONE);
			clock_ms += held;
			send_sample(1'b1, clock_ms, 1'b0, EV_NONE);
			if (k < n - 1 && $urandom_range(0, 3) != 0)
				clock_ms += $urandom_range(0, {16'd0, thr.click_gap_ms});
			else
				clock_ms += near(thr.click_gap_ms);
		end
		send_sample(1'b1, clock_ms, 1'b0, EV_NONE);
		clock_ms += {16'd0, thr.click_gap_ms} + 32'd1 + $urandom_range(0, 100);
		send_sample(1'b1, clock_ms, 1'b0, EV_NONE);
		clock_ms += $urandom_range(0, 50);
	endtask

	// Unstructured samples: random levels, stray or far-off timestamps
	task automatic run_noise();
		logic [31:0] now;
		repeat ($urandom_range(1, 4)) begin
			now = $urandom_range(0, 1) ? $urandom : clock_ms + $urandom_range(0, 1000);
			send_sample(1'($urandom_range(0, 1)), now, 1'b0, EV_NONE);
		end
	endtask

	initial begin
		cfg_t c;
		int   phase_end;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then the directed table
		apply_thresholds(thr, 1'b0);
		foreach (script[i])
			send_sample(script[i].level, script[i].stamp, script[i].typed, script[i].want);
		settle();

		for (int p = 0; p < Phases; p++) begin
			case (p)
				0: c = thr;
				1: c = '{16'd0, 16'd0, 16'd0};
				2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
				default: begin
					c.long_press_ms = $urandom_range(0, 2) == 0 ?
						16'($urandom) : 16'($urandom_range(0, 4000));
					c.debounce_ms = $urandom_range(0, 2) == 0 ?
						16'($urandom) : 16'($urandom_range(0, 300));
					c.click_gap_ms = $urandom_range(0, 2) == 0 ?
						16'($urandom) : 16'($urandom_range(0, 1000));
				end
			endcase
			if (p != 0)
				apply_thresholds(c, 1'b1);
			clock_ms = $urandom_range(0, 1) ? $urandom :
				32'hFFFF_FFFF - $urandom_range(0, 200000);
			phase_end = samples_sent + PhaseLen;
			while (samples_sent < phase_end) begin
				if ($urandom_range(0, 19) == 0)
					steady = !steady;
				if ($urandom_range(0, 6) == 0)
					run_noise();
				else
					run_gesture();
			end
			settle();
		end

		$display("Covered %0d samples over %0d threshold settings with random stalls.",
			samples_sent, Phases);
		$display("Events seen: %0d none, %0d single, %0d double, %0d long; %0d faults.",
			ev_tally[EV_NONE], ev_tally[EV_SINGLE], ev_tally[EV_DOUBLE],
			ev_tally[EV_LONG], fault_count);
		if (fault_count == 0)
			$display("button_click_classifier_test: done, clean");
		else
			$display("button_click_classifier_test: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("button_click_classifier_test: done, errors");
		$finish;
	end

endmodule
